### rtl/core/tcw_pkg.sv
package tcw_pkg;

   // Default console geometry
   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 25;

   // Cell word layout: attribute in the high byte, character in the low byte
   localparam int CELL_WIDTH = 16;
   localparam logic [7:0] ATTR_RESET = 8'h70;
   localparam logic [7:0] BLANK_CODE = 8'h20;

   // Character codes with special handling
   localparam logic [7:0] CODE_BS       = 8'd8;
   localparam logic [7:0] CODE_TAB      = 8'd9;
   localparam logic [7:0] CODE_NL       = 8'd10;
   localparam logic [7:0] CODE_CR       = 8'd13;
   localparam logic [7:0] CODE_PRINT_LO = 8'd32;
   localparam logic [7:0] CODE_PRINT_HI = 8'd126;

   // Item function codes
   localparam logic FUNC_PUT = 1'b0;
   localparam logic FUNC_SET = 1'b1;

   localparam int TAB_STEP    = 8;
   localparam int QUEUE_DEPTH = 2;

   // Decoded operation handed from the front end to the back end
   typedef enum logic [2:0] {
      OP_NOP,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_BACK,
      OP_PUT,
      OP_SET
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  code;
      logic [7:0]  col;
      logic [7:0]  row;
   } op_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_RUN,
      BK_COPY,
      BK_FILL
   } back_state_type;

endpackage

### rtl/core/tcw_req_if.sv
interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] char_code;
   logic [7:0] new_col;
   logic [7:0] new_row;

   modport source (output valid, output func, output char_code, output new_col,
                   output new_row, input ready);
   modport sink   (input valid, input func, input char_code, input new_col,
                   input new_row, output ready);
endinterface

### rtl/core/tcw_rsp_if.sv
interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic        cell_written;
   logic [10:0] cell_addr;
   logic [15:0] cell_data;
   logic        scrolled;
   logic [6:0]  cursor_col_out;
   logic [4:0]  cursor_row_out;

   modport source (output valid, output cell_written, output cell_addr,
                   output cell_data, output scrolled, output cursor_col_out,
                   output cursor_row_out, input ready);
   modport sink   (input valid, input cell_written, input cell_addr,
                   input cell_data, input scrolled, input cursor_col_out,
                   input cursor_row_out, output ready);
endinterface

### rtl/core/text_console_writer_top.sv
// Channel   Dir  Handshake        Payload
// req_ch    in   valid / ready    func, char_code, new_col, new_row
// rsp_ch    out  valid / ready    cell_written, cell_addr, cell_data, scrolled,
//                                 cursor_col_out, cursor_row_out
// csr_*     in   csr_we           csr_wdata (text_attr)
//
// An ordinary item passes the decode queue and the execute stage, and its result is held
// in the output register; with results taken, one item per cycle can follow.
// A scroll holds the execute stage through the row copy, then the last-row fill.
// After reset a clearing pass over all ROWS*COLS cells (2000 at 80x25) blanks the store;
// req_ch.ready stays low until it ends.
// A stalled result holds in the output register while the queue takes up to two items.
module text_console_writer_top #(
   parameter int COLS = tcw_pkg::DEF_COLS,
   parameter int ROWS = tcw_pkg::DEF_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_ch,
   tcw_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);
   import tcw_pkg::*;

   logic [7:0] text_attr_ff;
   logic       clearing;
   logic       push_valid, push_ready;
   op_type     push_op;
   logic       pop_valid, pop_ready;
   op_type     pop_op;

   // Attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff <= ATTR_RESET;
      end else if (csr_we) begin
         text_attr_ff <= csr_wdata;
      end
   end

   tcw_front #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_front (
      .req_ch     (req_ch),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   tcw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   tcw_back #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .text_attr (text_attr_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (pop_op),
      .clearing  (clearing),
      .rsp_ch    (rsp_ch)
   );

endmodule

### rtl/core/tcw_ram.sv
module tcw_ram #(
   parameter int WIDTH = tcw_pkg::CELL_WIDTH,
   parameter int DEPTH = tcw_pkg::DEF_COLS * tcw_pkg::DEF_ROWS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tcw_queue.sv
module tcw_queue #(
   parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  tcw_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output tcw_pkg::op_type pop_op
);
   import tcw_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [NW-1:0] COUNT_FULL = NW'(DEPTH);

   op_type         slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != COUNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued operations
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### rtl/core/tcw_front.sv
module tcw_front #(
   parameter int COLS = tcw_pkg::DEF_COLS,
   parameter int ROWS = tcw_pkg::DEF_ROWS
) (
   tcw_req_if.sink         req_ch,
   input  logic            clearing,
   output logic            push_valid,
   input  logic            push_ready,
   output tcw_pkg::op_type push_op
);
   import tcw_pkg::*;

   localparam logic [7:0] COL_LIMIT = 8'(COLS);
   localparam logic [7:0] ROW_LIMIT = 8'(ROWS);

   // Take items only once the store is cleared and the queue has room
   assign req_ch.ready = push_ready && !clearing;
   assign push_valid   = req_ch.valid && !clearing;

   // Classify the item
   always_comb begin
      push_op.code = req_ch.char_code;
      push_op.col  = req_ch.new_col;
      push_op.row  = req_ch.new_row;
      push_op.kind = OP_NOP;
      if (req_ch.func == FUNC_SET) begin
         if ((req_ch.new_col < COL_LIMIT) && (req_ch.new_row < ROW_LIMIT)) begin
            push_op.kind = OP_SET;
         end
      end else begin
         unique case (req_ch.char_code) inside
            CODE_NL:                       push_op.kind = OP_NEWLINE;
            CODE_CR:                       push_op.kind = OP_RETURN;
            CODE_TAB:                      push_op.kind = OP_TAB;
            CODE_BS:                       push_op.kind = OP_BACK;
            [CODE_PRINT_LO:CODE_PRINT_HI]: push_op.kind = OP_PUT;
            default:                       push_op.kind = OP_NOP;
         endcase
      end
   end

endmodule

### rtl/core/tcw_back.sv
module tcw_back #(
   parameter int COLS = tcw_pkg::DEF_COLS,
   parameter int ROWS = tcw_pkg::DEF_ROWS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      text_attr,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  tcw_pkg::op_type pop_op,
   output logic            clearing,
   tcw_rsp_if.source       rsp_ch
);
   import tcw_pkg::*;

   localparam int CELLS = COLS * ROWS;
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);
   localparam int AW    = $clog2(CELLS);
   localparam int SW    = $clog2(CELLS + 1);
   localparam int TW    = CW + 1;

   localparam logic [CW-1:0] COL_LAST      = CW'(COLS - 1);
   localparam logic [RW-1:0] ROW_LAST      = RW'(ROWS - 1);
   localparam logic [TW-1:0] TAB_ADD       = TW'(TAB_STEP);
   localparam logic [TW-1:0] TAB_MASK      = ~TW'(TAB_STEP - 1);
   localparam logic [TW-1:0] TAB_LIMIT     = TW'(COLS);
   localparam logic [SW-1:0] SWEEP_END     = SW'(CELLS);
   localparam logic [SW-1:0] SWEEP_LAST    = SW'(CELLS - 1);
   localparam logic [SW-1:0] SWEEP_COLS    = SW'(COLS);
   localparam logic [SW-1:0] LAST_ROW_BASE = SW'((ROWS - 1) * COLS);
   localparam logic [AW-1:0] ROW_PITCH     = AW'(COLS);

   back_state_type state_ff, state_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [SW-1:0]  sweep_ff, sweep_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  dst_ff, dst_in;
   logic [15:0]    fill_word_ff, fill_word_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_written_ff;
   logic [10:0]    rsp_addr_ff;
   logic [15:0]    rsp_data_ff;
   logic           rsp_scrolled_ff;
   logic [6:0]     rsp_col_ff;
   logic [4:0]     rsp_row_ff;

   // Execute-stage signals
   logic           rsp_free, exec;
   logic [CW-1:0]  col_n, wr_col;
   logic [RW-1:0]  row_n;
   logic           row_step, wrote, scroll;
   logic [15:0]    data;
   logic [TW-1:0]  tab_pos;
   logic [AW-1:0]  cell_addr;

   // Store port
   logic           ram_we;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [15:0]    ram_wdata, ram_rdata;

   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign pop_ready = (state_ff == BK_RUN) && rsp_free;
   assign exec      = pop_ready && pop_valid;
   assign clearing  = (state_ff == BK_CLEAR);

   // Work out the cursor move and the cell write of one operation
   always_comb begin
      col_n    = col_ff;
      wr_col   = col_ff;
      row_step = 1'b0;
      wrote    = 1'b0;
      data     = '0;
      tab_pos  = (TW'(col_ff) + TAB_ADD) & TAB_MASK;
      unique case (pop_op.kind)
         OP_NEWLINE: begin
            col_n    = '0;
            row_step = 1'b1;
         end
         OP_RETURN: begin
            col_n = '0;
         end
         OP_TAB: begin
            if (tab_pos >= TAB_LIMIT) begin
               col_n    = '0;
               row_step = 1'b1;
            end else begin
               col_n = CW'(tab_pos);
            end
         end
         OP_BACK: begin
            if (col_ff != '0) begin
               col_n  = col_ff - 1'b1;
               wr_col = col_ff - 1'b1;
               wrote  = 1'b1;
               data   = {text_attr, BLANK_CODE};
            end
         end
         OP_PUT: begin
            wrote = 1'b1;
            data  = {text_attr, pop_op.code};
            if (col_ff == COL_LAST) begin
               col_n    = '0;
               row_step = 1'b1;
            end else begin
               col_n = col_ff + 1'b1;
            end
         end
         OP_SET: begin
            col_n = CW'(pop_op.col);
         end
         default: begin
            col_n = col_ff;
         end
      endcase

      // Step the row; a step past the last row scrolls
      scroll = 1'b0;
      row_n  = row_ff;
      if (pop_op.kind == OP_SET) begin
         row_n = RW'(pop_op.row);
      end else if (row_step) begin
         if (row_ff == ROW_LAST) begin
            scroll = 1'b1;
         end else begin
            row_n = row_ff + 1'b1;
         end
      end
   end

   assign cell_addr = AW'(AW'(row_ff) * ROW_PITCH) + AW'(wr_col);

   // Sequence clearing, execution, row copy and last-row fill
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sweep_in     = sweep_ff;
      pend_in      = pend_ff;
      dst_in       = dst_ff;
      fill_word_in = fill_word_ff;
      ram_we       = 1'b0;
      ram_waddr    = sweep_ff[AW-1:0];
      ram_wdata    = fill_word_ff;
      ram_raddr    = sweep_ff[AW-1:0];
      unique case (state_ff)
         BK_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = {ATTR_RESET, BLANK_CODE};
            if (sweep_ff == SWEEP_LAST) begin
               sweep_in = '0;
               state_in = BK_RUN;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         BK_RUN: begin
            if (exec) begin
               ram_we    = wrote;
               ram_waddr = cell_addr;
               ram_wdata = data;
               col_in    = col_n;
               row_in    = row_n;
               if (scroll) begin
                  state_in     = BK_COPY;
                  sweep_in     = SWEEP_COLS;
                  pend_in      = 1'b0;
                  fill_word_in = {text_attr, BLANK_CODE};
               end
            end
         end
         BK_COPY: begin
            // Read one row down, write the word read last cycle one row up
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = dst_ff;
               ram_wdata = ram_rdata;
            end
            if (sweep_ff == SWEEP_END) begin
               pend_in  = 1'b0;
               sweep_in = LAST_ROW_BASE;
               state_in = BK_FILL;
            end else begin
               pend_in  = 1'b1;
               dst_in   = AW'(sweep_ff - SWEEP_COLS);
               sweep_in = sweep_ff + 1'b1;
            end
         end
         BK_FILL: begin
            ram_we = 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               sweep_in = '0;
               state_in = BK_RUN;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         col_ff   <= '0;
         row_ff   <= '0;
         sweep_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         sweep_ff <= sweep_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff       <= dst_in;
      fill_word_ff <= fill_word_in;
   end

   // Hold the result until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_written_ff  <= wrote;
         rsp_addr_ff     <= wrote ? 11'(cell_addr) : '0;
         rsp_data_ff     <= data;
         rsp_scrolled_ff <= scroll;
         rsp_col_ff      <= 7'(col_n);
         rsp_row_ff      <= 5'(row_n);
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.cell_written   = rsp_written_ff;
   assign rsp_ch.cell_addr      = rsp_addr_ff;
   assign rsp_ch.cell_data      = rsp_data_ff;
   assign rsp_ch.scrolled       = rsp_scrolled_ff;
   assign rsp_ch.cursor_col_out = rsp_col_ff;
   assign rsp_ch.cursor_row_out = rsp_row_ff;

   tcw_ram #(
      .WIDTH (CELL_WIDTH),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

### rtl/core/tcw_checker.sv
module tcw_checker #(
   parameter int ROWS = tcw_pkg::DEF_ROWS
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_cell_written,
   input logic [10:0] rsp_cell_addr,
   input logic [15:0] rsp_cell_data,
   input logic        rsp_scrolled,
   input logic [6:0]  rsp_cursor_col_out,
   input logic [4:0]  rsp_cursor_row_out
);

   localparam logic [4:0] ROW_LAST_OUT = 5'(ROWS - 1);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_addr)
         && $stable(rsp_cell_data) && $stable(rsp_cursor_col_out)
         && $stable(rsp_cursor_row_out))
      else $error("result changed while stalled");

   // No write reports a zero address and word
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cell_written |-> rsp_cell_addr == '0 && rsp_cell_data == '0)
      else $error("address or data set without a cell write");

   // A scroll leaves the cursor on the last row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_row_out == ROW_LAST_OUT)
      else $error("scroll left the cursor off the last row");

   // The store clear blocks items right after reset
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("item taken during store clear");

endmodule

bind text_console_writer_top tcw_checker #(
   .ROWS (ROWS)
) u_tcw_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_cell_written   (rsp_ch.cell_written),
   .rsp_cell_addr      (rsp_ch.cell_addr),
   .rsp_cell_data      (rsp_ch.cell_data),
   .rsp_scrolled       (rsp_ch.scrolled),
   .rsp_cursor_col_out (rsp_ch.cursor_col_out),
   .rsp_cursor_row_out (rsp_ch.cursor_row_out)
);

### tb/tb_text_console_writer_top.sv
`timescale 1ns / 1ps

module tb_text_console_writer_top;
   import tcw_pkg::*;

   localparam int NCOLS             = DEF_COLS;
   localparam int NROWS             = DEF_ROWS;
   localparam int CELLS             = NCOLS * NROWS;
   localparam int SCROLLS_PER_PHASE = 30;
   localparam int RANDOM_ITEMS      = 400;
   localparam int CYCLE_LIMIT       = 1_500_000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic       func;
      logic [7:0] char_code;
      logic [7:0] new_col;
      logic [7:0] new_row;
   } console_cmd_type;

   typedef struct packed {
      logic        cell_written;
      logic [10:0] cell_addr;
      logic [15:0] cell_data;
      logic        scrolled;
      logic [6:0]  cursor_col_out;
      logic [4:0]  cursor_row_out;
   } console_update_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'h00;
   logic       result_ready = 1'b0;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   assign rsp_ch.ready = result_ready;

   text_console_writer_top #(
      .COLS(NCOLS),
      .ROWS(NROWS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // Console state as the block should hold it
   logic [7:0] text_attr = ATTR_RESET;
   int cur_col = 0;
   int cur_row = 0;

   console_update_type expected_updates[$];

   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int mismatches    = 0;
   int items_sent    = 0;
   int scrolls_seen  = 0;
   int writes_seen   = 0;
   int attr_settings = 1;
   int cycle_count   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d updates outstanding", cycle_count,
                  expected_updates.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Work out the update one command causes and advance the cursor
   function automatic console_update_type predict_console_update(input console_cmd_type cmd);
      console_update_type upd;
      int col;
      int row;
      upd = '0;
      col = cur_col;
      row = cur_row;
      if (cmd.func == FUNC_SET) begin
         if (cmd.new_col < NCOLS && cmd.new_row < NROWS) begin
            col = cmd.new_col;
            row = cmd.new_row;
         end
      end else begin
         case (cmd.char_code)
            CODE_NL: begin
               col = 0;
               row++;
            end
            CODE_CR: col = 0;
            CODE_TAB: begin
               col = (col + TAB_STEP) & ~(TAB_STEP - 1);
               if (col >= NCOLS) begin
                  col = 0;
                  row++;
               end
            end
            CODE_BS: begin
               if (col > 0) begin
                  col--;
                  upd.cell_written = 1'b1;
                  upd.cell_addr    = 11'(row * NCOLS + col);
                  upd.cell_data    = {text_attr, BLANK_CODE};
               end
            end
            default: begin
               if (cmd.char_code >= CODE_PRINT_LO && cmd.char_code <= CODE_PRINT_HI) begin
                  upd.cell_written = 1'b1;
                  upd.cell_addr    = 11'(row * NCOLS + col);
                  upd.cell_data    = {text_attr, cmd.char_code};
                  col++;
                  if (col >= NCOLS) begin
                     col = 0;
                     row++;
                  end
               end
            end
         endcase
         // Falling off the bottom scrolls the store and pins the cursor to the last row
         if (row >= NROWS) begin
            row = NROWS - 1;
            upd.scrolled = 1'b1;
            scrolls_seen++;
         end
      end
      if (upd.cell_written)
         writes_seen++;
      cur_col = col;
      cur_row = row;
      upd.cursor_col_out = 7'(col);
      upd.cursor_row_out = 5'(row);
      return upd;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted update with the oldest expectation; stall at random
   always @(posedge clock) begin
      console_update_type want;
      if (!reset && rsp_ch.valid && result_ready) begin
         if (expected_updates.size() == 0) begin
            $display("%0t: unexpected update, expected none, actual addr %0d data 0x%0h",
                     $time, rsp_ch.cell_addr, rsp_ch.cell_data);
            mismatches++;
         end else begin
            want = expected_updates.pop_front();
            check_field("cell_written", 16'(want.cell_written), 16'(rsp_ch.cell_written));
            check_field("cell_addr", 16'(want.cell_addr), 16'(rsp_ch.cell_addr));
            check_field("cell_data", want.cell_data, rsp_ch.cell_data);
            check_field("scrolled", 16'(want.scrolled), 16'(rsp_ch.scrolled));
            check_field("cursor_col_out", 16'(want.cursor_col_out),
                        16'(rsp_ch.cursor_col_out));
            check_field("cursor_row_out", 16'(want.cursor_row_out),
                        16'(rsp_ch.cursor_row_out));
         end
      end
      result_ready <= ($urandom_range(99) >= rcv_stall_pct);
   end

   function automatic console_cmd_type put_cmd(input logic [7:0] code);
      return '{func: FUNC_PUT, char_code: code, new_col: 8'd0, new_row: 8'd0};
   endfunction

   function automatic console_cmd_type set_cmd(input logic [7:0] col, input logic [7:0] row);
      return '{func: FUNC_SET, char_code: 8'hFF, new_col: col, new_row: row};
   endfunction

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            rcv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 64;
            rcv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            rcv_stall_pct = 64;
         end
         default: begin
            send_idle_pct = 16;
            rcv_stall_pct = 16;
         end
      endcase
   endtask

   // Send one item, with a random gap ahead of it, and record its expected update
   task automatic send_item(input console_cmd_type cmd);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= cmd.func;
      req_ch.char_code <= cmd.char_code;
      req_ch.new_col   <= cmd.new_col;
      req_ch.new_row   <= cmd.new_row;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      expected_updates.push_back(predict_console_update(cmd));
      items_sent++;
   endtask

   // Hold the sender until every expected update has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_updates.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_text_attr(input logic [7:0] attr);
      drain_results();
      // let a trailing row copy and fill finish before touching the attribute
      repeat (CELLS + 8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= attr;
      @(posedge clock);
      csr_we    <= 1'b0;
      text_attr = attr;
      attr_settings++;
   endtask

   // Printable range edges, ignored codes and the simple control codes from home
   task automatic test_printable_and_controls();
      set_idle_mode(IDLE_NONE);
      send_item(put_cmd("A"));
      send_item(put_cmd(CODE_PRINT_LO));
      send_item(put_cmd(CODE_PRINT_HI));
      send_item(put_cmd(8'd127));
      send_item(put_cmd(8'd0));
      send_item(put_cmd(8'd255));
      send_item(put_cmd(8'd31));
      send_item(put_cmd(8'd128));
      send_item(put_cmd(CODE_CR));
      send_item(put_cmd(CODE_BS));
      send_item(put_cmd("x"));
      send_item(put_cmd(CODE_BS));
      send_item(put_cmd(CODE_TAB));
      send_item(put_cmd(CODE_TAB));
   endtask

   // Cursor moves, rejected positions, row wrap and every way to scroll
   task automatic test_cursor_wrap_and_scroll();
      set_idle_mode(IDLE_BOTH);
      send_item(set_cmd(8'(NCOLS - 1), 8'd0));
      send_item(put_cmd("Z"));
      send_item(set_cmd(8'(NCOLS), 8'd0));
      send_item(set_cmd(8'd0, 8'(NROWS)));
      send_item(set_cmd(8'd255, 8'd255));
      send_item(set_cmd(8'(NCOLS - TAB_STEP), 8'd3));
      send_item(put_cmd(CODE_TAB));
      send_item(set_cmd(8'(NCOLS - 1), 8'(NROWS - 1)));
      send_item(put_cmd("~"));
      send_item(put_cmd(CODE_NL));
      send_item(set_cmd(8'(NCOLS - 5), 8'(NROWS - 1)));
      send_item(put_cmd(CODE_TAB));
   endtask

   // Mostly text with control codes and cursor moves, some noise; scrolls are rationed
   task automatic test_random_traffic(input int n_items, input idle_mode_type mode,
                                      input logic [7:0] attr);
      console_cmd_type cmd;
      int counted;
      int pick;
      int scrolls_at_start;
      bit counts;
      write_text_attr(attr);
      set_idle_mode(mode);
      scrolls_at_start = scrolls_seen;
      counted = 0;
      while (counted < n_items) begin
         cmd.func      = FUNC_PUT;
         cmd.char_code = 8'($urandom_range(255));
         cmd.new_col   = 8'($urandom_range(255));
         cmd.new_row   = 8'($urandom_range(255));
         counts = 1'b1;
         pick = $urandom_range(99);
         if (scrolls_seen - scrolls_at_start >= SCROLLS_PER_PHASE && cur_row == NROWS - 1) begin
            // scroll budget spent: move off the last row
            cmd.func    = FUNC_SET;
            cmd.new_col = 8'($urandom_range(NCOLS - 1));
            cmd.new_row = 8'($urandom_range(NROWS - 2));
         end else if (pick < 60) begin
            cmd.char_code = 8'($urandom_range(CODE_PRINT_HI, CODE_PRINT_LO));
         end else if (pick < 66) begin
            cmd.char_code = CODE_NL;
         end else if (pick < 70) begin
            cmd.char_code = CODE_CR;
         end else if (pick < 75) begin
            cmd.char_code = CODE_TAB;
         end else if (pick < 80) begin
            cmd.char_code = CODE_BS;
         end else if (pick < 88) begin
            cmd.func    = FUNC_SET;
            cmd.new_col = 8'($urandom_range(NCOLS - 1));
            cmd.new_row = 8'($urandom_range(NROWS - 1));
         end else if (pick < 94) begin
            cmd.func = FUNC_SET;
            counts   = (cmd.new_col < NCOLS && cmd.new_row < NROWS);
         end else begin
            counts = 1'b0;
         end
         send_item(cmd);
         if (counts) begin
            counted++;
            if (counted == n_items / 2)
               drain_results();
         end
      end
   endtask

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.func      <= FUNC_PUT;
      req_ch.char_code <= 8'd0;
      req_ch.new_col   <= 8'd0;
      req_ch.new_row   <= 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_printable_and_controls();
      test_cursor_wrap_and_scroll();
      test_random_traffic(RANDOM_ITEMS, IDLE_NONE, 8'h00);
      test_random_traffic(RANDOM_ITEMS, IDLE_SENDER, 8'hFF);
      test_random_traffic(RANDOM_ITEMS, IDLE_RECEIVER, 8'($urandom_range(254, 1)));
      test_random_traffic(RANDOM_ITEMS, IDLE_BOTH, 8'($urandom_range(254, 1)));

      drain_results();
      repeat (CELLS + 20) @(posedge clock);

      $display("Run covered %0d items: %0d cell writes, %0d scrolls, %0d attribute settings",
               items_sent, writes_seen, scrolls_seen, attr_settings);
      $display("Flow control: free running, sender gaps, receiver stalls and both mixed");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### text_console_writer_top.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_req_if.sv
rtl/core/tcw_rsp_if.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_front.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer_top.sv
rtl/core/tcw_checker.sv
tb/tb_text_console_writer_top.sv
